// ===== sv/rmf_pkg.sv =====
// rmf_pkg: shared types and constants for the recursive mutex with fifo handoff
// no dependencies; imported by rmf_ram users and recursive_mutex_fifo_handoff
`timescale 1ns / 1ps
`default_nettype none

package rmf_pkg;

    localparam int TASKS_DEF      = 64;
    localparam int COUNT_BITS_DEF = 8;
    localparam int TASK_W         = 6;
    localparam int STATUS_W       = 4;
    localparam int HOLD_W         = 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACQUIRED   = 4'd0,
        ST_NESTED     = 4'd1,
        ST_QUEUED     = 4'd2,
        ST_QUEUE_FULL = 4'd3,
        ST_SATURATED  = 4'd4,
        ST_PARTIAL    = 4'd5,
        ST_FREED      = 4'd6,
        ST_HANDOFF    = 4'd7,
        ST_NOT_OWNER  = 4'd8
    } t_status;

    localparam logic KIND_LOCK   = 1'b0;
    localparam logic KIND_UNLOCK = 1'b1;

endpackage

`default_nettype wire

// ===== sv/rmf_ram.sv =====
// rmf_ram: generic single write port, single read port ram with registered read
// no dependencies; read returns the old contents on a same-address write
`timescale 1ns / 1ps
`default_nettype none

module rmf_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== sv/recursive_mutex_fifo_handoff.sv =====
// an accepted item is captured in the input register, then its result is registered and strobed on o_strobe
// throughput: one item per cycle, busy stays low; the receiver cannot stall
// the wait queue head is prefetched from the ram so a handoff does not wait for a ram read
// reset: synchronous active low; lock free, queue empty, no result pending
// the wait queue ram needs no clearing pass, entries are read only after written
// depends on rmf_pkg and rmf_ram
`timescale 1ns / 1ps
`default_nettype none

module recursive_mutex_fifo_handoff #(
    parameter int TASKS      = rmf_pkg::TASKS_DEF,
    parameter int COUNT_BITS = rmf_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_kind,
    input  wire logic [rmf_pkg::TASK_W-1:0]    i_task_id,
    output logic                               o_strobe,
    output logic      [rmf_pkg::STATUS_W-1:0]  o_status,
    output logic                               o_woken_valid,
    output logic      [rmf_pkg::TASK_W-1:0]    o_woken_task,
    output logic                               o_owner_valid,
    output logic      [rmf_pkg::TASK_W-1:0]    o_owner_task,
    output logic      [rmf_pkg::HOLD_W-1:0]    o_hold_count
);

    import rmf_pkg::*;

    localparam int PTR_W  = $clog2(TASKS);
    localparam int FILL_W = $clog2(TASKS + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [PTR_W-1:0]      PTR_LAST   = PTR_W'(TASKS - 1);
    localparam logic [FILL_W-1:0]     FILL_FULL  = FILL_W'(TASKS);

    // input register
    logic              r_in_valid;
    logic              r_kind;
    logic [TASK_W-1:0] r_task;

    // lock state
    logic                  r_held,    n_held;
    logic [TASK_W-1:0]     r_owner,   n_owner;
    logic [COUNT_BITS-1:0] r_nesting, n_nesting;
    logic [PTR_W-1:0]      r_head,    n_head;
    logic [PTR_W-1:0]      r_tail,    n_tail;
    logic [FILL_W-1:0]     r_fill,    n_fill;

    // head prefetch bypass
    logic              r_byp_hit;
    logic [TASK_W-1:0] r_byp_data;
    logic [TASK_W-1:0] w_ram_rdata;
    logic [TASK_W-1:0] w_head_task;

    logic    w_wr_en;
    t_status n_status;
    logic    n_woken_valid;
    logic [TASK_W-1:0] n_woken_task;
    logic [31:0]       w_cnt_ext;

    assign busy        = 1'b0;
    assign w_head_task = r_byp_hit ? r_byp_data : w_ram_rdata;

    rmf_ram #(
        .WIDTH (TASK_W),
        .DEPTH (TASKS)
    ) u_wait_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (r_task),
        .i_rd_addr (n_head),
        .o_rd_data (w_ram_rdata)
    );

    always_comb begin
        n_held        = r_held;
        n_owner       = r_owner;
        n_nesting     = r_nesting;
        n_head        = r_head;
        n_tail        = r_tail;
        n_fill        = r_fill;
        n_status      = ST_NOT_OWNER;
        n_woken_valid = 1'b0;
        n_woken_task  = '0;
        w_wr_en       = 1'b0;
        if (r_in_valid) begin
            if (r_kind == KIND_LOCK) begin
                if (!r_held) begin
                    n_held    = 1'b1;
                    n_owner   = r_task;
                    n_nesting = COUNT_BITS'(1);
                    n_status  = ST_ACQUIRED;
                end else if (r_owner == r_task) begin
                    if (r_nesting == COUNT_MAX) begin
                        n_status = ST_SATURATED;
                    end else begin
                        n_nesting = r_nesting + COUNT_BITS'(1);
                        n_status  = ST_NESTED;
                    end
                end else if (r_fill >= FILL_FULL) begin
                    n_status = ST_QUEUE_FULL;
                end else begin
                    w_wr_en  = 1'b1;
                    n_tail   = (r_tail == PTR_LAST) ? '0 : r_tail + PTR_W'(1);
                    n_fill   = r_fill + FILL_W'(1);
                    n_status = ST_QUEUED;
                end
            end else begin
                if (!r_held || r_owner != r_task) begin
                    n_status = ST_NOT_OWNER;
                end else if (r_nesting != COUNT_BITS'(1)) begin
                    n_nesting = r_nesting - COUNT_BITS'(1);
                    n_status  = ST_PARTIAL;
                end else if (r_fill != '0) begin
                    n_woken_valid = 1'b1;
                    n_woken_task  = w_head_task;
                    n_owner       = w_head_task;
                    n_nesting     = COUNT_BITS'(1);
                    n_head        = (r_head == PTR_LAST) ? '0 : r_head + PTR_W'(1);
                    n_fill        = r_fill - FILL_W'(1);
                    n_status      = ST_HANDOFF;
                end else begin
                    n_held    = 1'b0;
                    n_owner   = '0;
                    n_nesting = '0;
                    n_status  = ST_FREED;
                end
            end
        end
    end

    assign w_cnt_ext = 32'(n_nesting);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_held     <= 1'b0;
            r_owner    <= '0;
            r_nesting  <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_fill     <= '0;
            r_byp_hit  <= 1'b0;
            o_strobe   <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
            r_held     <= n_held;
            r_owner    <= n_owner;
            r_nesting  <= n_nesting;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_fill     <= n_fill;
            r_byp_hit  <= w_wr_en && (r_tail == n_head);
            o_strobe   <= r_in_valid;
        end
        r_kind        <= i_kind;
        r_task        <= i_task_id;
        r_byp_data    <= r_task;
        o_status      <= n_status;
        o_woken_valid <= n_woken_valid;
        o_woken_task  <= n_woken_task;
        o_owner_valid <= n_held;
        o_owner_task  <= n_owner;
        o_hold_count  <= w_cnt_ext[HOLD_W-1:0];
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("wait queue fill above depth");

    a_held_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> (r_nesting != '0))
        else $error("lock held with zero nesting count");

    a_free_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_held |-> (r_owner == '0 && r_nesting == '0))
        else $error("free lock keeps owner or count");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_strobe)
        else $error("accepted item produced no result");

    a_woken_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_woken_valid) |-> (o_status == ST_HANDOFF && o_owner_valid
            && o_owner_task == o_woken_task))
        else $error("woken task without handoff");
`endif

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// testbench for recursive_mutex_fifo_handoff: directed, burst and random lock/unlock items
// checked against an in-bench lock predictor held in a small scoreboard class
// depends on rmf_pkg and the recursive_mutex_fifo_handoff rtl
`timescale 1ns / 1ps

module testbench;
    import rmf_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 540;
    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                woken_valid;
        logic [TASK_W-1:0]   woken_task;
        logic                owner_valid;
        logic [TASK_W-1:0]   owner_task;
        logic [HOLD_W-1:0]   hold_count;
    } t_lock_result;

    class lock_scoreboard;
        bit                held;
        bit [TASK_W-1:0]   owner;
        bit [HOLD_W-1:0]   nesting;
        bit [TASK_W-1:0]   wait_ring[TASKS_DEF];
        bit [TASK_W-1:0]   head;
        bit [TASK_W-1:0]   tail;
        bit [TASK_W:0]     fill;
        t_lock_result      expected_q[$];
        int                errors;
        int                checked;
        int                status_seen[9];

        function void note_request(logic kind, logic [TASK_W-1:0] id);
            t_lock_result r;
            r = '0;
            if (kind == KIND_LOCK) begin
                if (!held) begin
                    held = 1'b1;
                    owner = id;
                    nesting = HOLD_W'(1);
                    r.status = ST_ACQUIRED;
                end else if (owner == id) begin
                    if (nesting == HOLD_MAX) begin
                        r.status = ST_SATURATED;
                    end else begin
                        nesting++;
                        r.status = ST_NESTED;
                    end
                end else if (fill == TASKS_DEF) begin
                    r.status = ST_QUEUE_FULL;
                end else begin
                    wait_ring[tail] = id;
                    tail++;
                    fill++;
                    r.status = ST_QUEUED;
                end
            end else begin
                if (!held || owner != id) begin
                    r.status = ST_NOT_OWNER;
                end else begin
                    nesting--;
                    if (nesting != 0) begin
                        r.status = ST_PARTIAL;
                    end else if (fill != 0) begin
                        r.woken_valid = 1'b1;
                        r.woken_task = wait_ring[head];
                        head++;
                        fill--;
                        owner = r.woken_task;
                        nesting = HOLD_W'(1);
                        r.status = ST_HANDOFF;
                    end else begin
                        held = 1'b0;
                        owner = '0;
                        r.status = ST_FREED;
                    end
                end
            end
            r.owner_valid = held;
            r.owner_task = held ? owner : '0;
            r.hold_count = nesting;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_lock_result got);
            t_lock_result exp;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result at %0t: status=%0d", $realtime, got.status);
                return;
            end
            exp = expected_q.pop_front();
            checked++;
            status_seen[exp.status]++;
            if (got.status !== exp.status || got.woken_valid !== exp.woken_valid ||
                got.woken_task !== exp.woken_task || got.owner_valid !== exp.owner_valid ||
                got.owner_task !== exp.owner_task || got.hold_count !== exp.hold_count) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch %0t: exp st=%0d wk=%0b/%0d own=%0b/%0d cnt=%0d",
                             $realtime, exp.status, exp.woken_valid, exp.woken_task,
                             exp.owner_valid, exp.owner_task, exp.hold_count);
                    $display("          got st=%0d wk=%0b/%0d own=%0b/%0d cnt=%0d",
                             got.status, got.woken_valid, got.woken_task,
                             got.owner_valid, got.owner_task, got.hold_count);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                i_kind = KIND_LOCK;
    logic [TASK_W-1:0]   i_task_id = '0;
    logic                o_strobe;
    logic [STATUS_W-1:0] o_status;
    logic                o_woken_valid;
    logic [TASK_W-1:0]   o_woken_task;
    logic                o_owner_valid;
    logic [TASK_W-1:0]   o_owner_task;
    logic [HOLD_W-1:0]   o_hold_count;

    lock_scoreboard sb = new();
    bit             idle_on = 1'b1;
    int             cycles = 0;

    recursive_mutex_fifo_handoff uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_task_id     (i_task_id),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_woken_valid (o_woken_valid),
        .o_woken_task  (o_woken_task),
        .o_owner_valid (o_owner_valid),
        .o_owner_task  (o_owner_task),
        .o_hold_count  (o_hold_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("** recursive_mutex_fifo_handoff: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_request(i_kind, i_task_id);
            if (o_strobe)
                sb.check_result({o_status, o_woken_valid, o_woken_task,
                                 o_owner_valid, o_owner_task, o_hold_count});
        end
    end

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_request(input logic kind, input logic [TASK_W-1:0] id);
        int gap;
        gap = (idle_on && $urandom_range(99) < 27) ? $urandom_range(1, 4) : 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_kind <= kind;
        i_task_id <= id;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic release_all();
        while (sb.held)
            send_request(KIND_UNLOCK, sb.owner);
    endtask

    initial begin
        logic [TASK_W-1:0] id;
        int                pick;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: free unlock, acquire, nest, queue with a repeated waiter, handoffs, free
        send_request(KIND_UNLOCK, 6'd0);
        send_request(KIND_LOCK, 6'd0);
        send_request(KIND_LOCK, 6'd0);
        send_request(KIND_LOCK, 6'd63);
        send_request(KIND_LOCK, 6'd63);
        send_request(KIND_LOCK, 6'd21);
        send_request(KIND_UNLOCK, 6'd63);
        send_request(KIND_UNLOCK, 6'd0);
        send_request(KIND_UNLOCK, 6'd0);
        send_request(KIND_UNLOCK, 6'd63);
        send_request(KIND_LOCK, 6'd63);
        send_request(KIND_UNLOCK, 6'd63);
        send_request(KIND_UNLOCK, 6'd63);
        send_request(KIND_UNLOCK, 6'd21);
        send_request(KIND_LOCK, 6'd42);
        send_request(KIND_UNLOCK, 6'd63);
        send_request(KIND_UNLOCK, 6'd42);

        // fill the wait queue past full, then hand the lock down the queue
        id = TASK_W'($urandom_range(0, 63));
        send_request(KIND_LOCK, id);
        repeat (TASKS_DEF + 3)
            send_request(KIND_LOCK, id + TASK_W'($urandom_range(1, 63)));
        release_all();

        // nest up to the count limit and beyond, then unwind
        id = TASK_W'($urandom_range(0, 63));
        repeat (int'(HOLD_MAX) + 2)
            send_request(KIND_LOCK, id);
        release_all();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on = !(n >= 200 && n < 400);
            pick = $urandom_range(99);
            if (sb.held) begin
                if (pick < 45)
                    send_request(KIND_UNLOCK, sb.owner);
                else if (pick < 60)
                    send_request(KIND_LOCK, sb.owner);
                else if (pick < 85)
                    send_request(KIND_LOCK, TASK_W'($urandom_range(0, 63)));
                else
                    send_request(logic'($urandom_range(1)), TASK_W'($urandom_range(0, 63)));
            end else begin
                if (pick < 60)
                    send_request(KIND_LOCK, TASK_W'($urandom_range(0, 63)));
                else
                    send_request(logic'($urandom_range(1)), TASK_W'($urandom_range(0, 63)));
            end
        end
        start <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d results checked: acquired %0d, nested %0d, queued %0d",
                 sb.checked, sb.status_seen[ST_ACQUIRED], sb.status_seen[ST_NESTED],
                 sb.status_seen[ST_QUEUED]);
        $display("queue full %0d, saturated %0d, partial %0d, freed %0d",
                 sb.status_seen[ST_QUEUE_FULL], sb.status_seen[ST_SATURATED],
                 sb.status_seen[ST_PARTIAL], sb.status_seen[ST_FREED]);
        $display("handed off %0d, not owner %0d; failures %0d",
                 sb.status_seen[ST_HANDOFF], sb.status_seen[ST_NOT_OWNER], sb.errors);
        if (sb.errors == 0)
            $display("** recursive_mutex_fifo_handoff: PASSED **");
        else
            $display("** recursive_mutex_fifo_handoff: FAILED **");
        $finish;
    end

endmodule

// ===== recursive_mutex_fifo_handoff.f =====
sv/rmf_pkg.sv
sv/rmf_ram.sv
sv/recursive_mutex_fifo_handoff.sv
dv/testbench.sv
